/* src/nonstationary_helix_inverse_filter_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the nonstationary helix inverse filter
// Clocked implication checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef NONSTATIONARY_HELIX_INVERSE_FILTER_CORE_ASSERT_SVH
`define NONSTATIONARY_HELIX_INVERSE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NHIF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define NHIF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NHIF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define NHIF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/nhif_pkg.sv */
// ---------------------------------------------------------------------------
// nhif_pkg
// Shared sizes and codes of the nonstationary helix inverse filter.
// ---------------------------------------------------------------------------
package nhif_pkg;

  // filter bank and window sizes
  localparam int NUM_PATCHES     = 16;
  localparam int TAPS_PER_FILTER = 8;
  localparam int WINDOW_DEPTH    = 256;
  localparam int TAP_DEPTH       = NUM_PATCHES * TAPS_PER_FILTER;

  // field widths
  localparam int PATCH_W  = 4;
  localparam int SLOT_W   = 3;
  localparam int LAG_W    = 8;
  localparam int COEF_W   = 18;
  localparam int SAMPLE_W = 24;
  localparam int POS_W    = 21;
  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POS_W;

  // derived widths
  localparam int TAP_SW = (TAPS_PER_FILTER > 1) ? $clog2(TAPS_PER_FILTER) : 1;
  localparam int TAP_AW = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int PROD_W = COEF_W + WORD_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS_PER_FILTER + 1) + 2;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADJOINT_MODE = 2'd0,
    REG_ADD_MODE     = 2'd1,
    REG_DATA_LENGTH  = 2'd2
  } cfg_reg_t;

endpackage

/* src/nhif_if.sv */
// ---------------------------------------------------------------------------
// nhif channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ---------------------------------------------------------------------------

// input word: tap load or data sample
interface nhif_item_if;
  import nhif_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [PATCH_W-1:0]         patch_select;
  logic [SLOT_W-1:0]          tap_slot;
  logic [LAG_W-1:0]           tap_lag;
  logic signed [COEF_W-1:0]   tap_coef;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic signed [SAMPLE_W-1:0] prior_value;

  modport source (output valid, command, patch_select, tap_slot, tap_lag, tap_coef,
                  sample_value, prior_value, input ready);
  modport sink   (input valid, command, patch_select, tap_slot, tap_lag, tap_coef,
                  sample_value, prior_value, output ready);
endinterface

// result word
interface nhif_result_if;
  import nhif_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] result_value;
  logic                       saturated;
  logic                       last_sample;

  modport source (output valid, result_value, saturated, last_sample, input ready);
  modport sink   (input valid, result_value, saturated, last_sample, output ready);
endinterface

// register write
interface nhif_cfg_if;
  import nhif_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/nonstationary_helix_inverse_filter_core.sv */
// A tap load gives no result. A sample steps through the start and head states,
// the tap loop, then the rounding and final states; each used tap costs a tap
// read, a window read, one pass through the shared 18x32 multiplier and one
// accumulate/write-back. Throughput: one sample at a time; the input is ready
// only while idle, and the last step waits while the previous result word is
// still unread.
`include "nonstationary_helix_inverse_filter_core_assert.svh"
// ---------------------------------------------------------------------------
// nonstationary_helix_inverse_filter_core
// Recursive helix polynomial division and its adjoint, one tap per pass
// through a shared multiplier under a small sequencer.
// Reset (rst, synchronous): taps unused, window empty, position 0, forward mode.
// ---------------------------------------------------------------------------
module nonstationary_helix_inverse_filter_core (
  input  logic               clk,
  input  logic               rst,
  nhif_item_if.sink          item,
  nhif_result_if.source      result,
  nhif_cfg_if.sink           cfg
);
  import nhif_pkg::*;

  localparam int SAT_IN_W = 64;
  localparam int PRODX_W  = PROD_W + 1;
  localparam int RND_HALF = 1 << (FRAC_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_HEAD, S_TAP, S_LAG, S_WIN, S_ACC, S_RND, S_FIN
  } state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     clip;
  } sat32_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clip;
  } sat24_t;

  // clip to the signed 32-bit range
  function automatic sat32_t sat_s32(input logic signed [SAT_IN_W-1:0] v);
    sat32_t r;
    r.clip  = 1'b0;
    r.value = v[WORD_W-1:0];
    if (v > SAT_IN_W'(64'sh7FFF_FFFF)) begin
      r.clip  = 1'b1;
      r.value = 32'sh7FFF_FFFF;
    end else if (v < -SAT_IN_W'(64'sh8000_0000)) begin
      r.clip  = 1'b1;
      r.value = -32'sh8000_0000;
    end
    return r;
  endfunction

  // clip to the signed 24-bit range
  function automatic sat24_t sat_s24(input logic signed [SAT_IN_W-1:0] v);
    sat24_t r;
    r.clip  = 1'b0;
    r.value = v[SAMPLE_W-1:0];
    if (v > SAT_IN_W'(64'sh7F_FFFF)) begin
      r.clip  = 1'b1;
      r.value = 24'sh7F_FFFF;
    end else if (v < -SAT_IN_W'(64'sh80_0000)) begin
      r.clip  = 1'b1;
      r.value = -24'sh80_0000;
    end
    return r;
  endfunction

  // control and configuration
  state_t             state;
  logic [POS_W-1:0]   position;
  logic               adjoint_mode;
  logic               add_mode;
  logic [POS_W-1:0]   data_length;
  logic [TAP_SW-1:0]  tap_t;
  logic               out_valid;

  // memories and their valid bits
  logic [LAG_W+COEF_W-1:0] tap_mem [TAP_DEPTH];
  logic [TAP_DEPTH-1:0]    tap_vld;
  logic [WORD_W-1:0]       win_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_vld;

  // registered read data
  logic [LAG_W+COEF_W-1:0] tap_rd;
  logic                    tap_rd_vld;
  logic [WORD_W-1:0]       win_rd_data;
  logic                    win_rd_vld;

  // per-sample working registers
  logic [PATCH_W-1:0]         patch_r;
  logic                       has_taps;
  logic [POS_W-1:0]           iy;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] prior_r;
  logic signed [ACC_W-1:0]    acc;
  logic signed [WORD_W-1:0]   tt;
  logic                       flag32;
  logic signed [PROD_W-1:0]   prod;
  logic [WIN_AW-1:0]          tap_waddr;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       out_sat;
  logic                       out_last;

  // combinational
  logic                     item_acc;
  logic                     is_sample;
  logic                     load_ok;
  logic [TAP_AW-1:0]        load_addr;
  logic [TAP_AW-1:0]        tap_addr;
  logic [POS_W-1:0]         len_m1;
  logic [POS_W-1:0]         pos_iy;
  logic                     pos_last;
  logic [LAG_W-1:0]         lag_m;
  logic signed [COEF_W-1:0] coef_m;
  logic                     tap_use;
  logic                     last_tap;
  logic [WIN_AW-1:0]        lag_addr;
  logic signed [WORD_W-1:0] w_old;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [PRODX_W-1:0] prod_half;
  logic signed [PRODX_W-1:0] prod_rnd;
  sat32_t                   head_sat;
  sat32_t                   fwd_sat;
  sat32_t                   adj_sat;
  sat24_t                   fin_sat;
  logic                     fin_go;
  logic                     win_re;
  logic [WIN_AW-1:0]        win_raddr;
  logic                     win_we;
  logic [WIN_AW-1:0]        win_waddr;
  logic [WORD_W-1:0]        win_wdata;

  // handshakes
  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_acc   = item.valid && item.ready;
  assign is_sample  = (item.command == CMD_SAMPLE);

  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.saturated    = out_sat;
  assign result.last_sample  = out_last;

  // tap load address
  assign load_ok   = (int'(item.patch_select) < NUM_PATCHES) &&
                     (int'(item.tap_slot) < TAPS_PER_FILTER);
  assign load_addr = TAP_AW'(TAP_AW'(item.patch_select) * TAP_AW'(TAPS_PER_FILTER) +
                             TAP_AW'(item.tap_slot));
  assign tap_addr  = TAP_AW'(TAP_AW'(patch_r) * TAP_AW'(TAPS_PER_FILTER) + TAP_AW'(tap_t));

  // sample index and end of set; a zero length acts as one
  assign len_m1   = (data_length == '0) ? '0 : data_length - POS_W'(1);
  assign pos_iy   = !adjoint_mode ? position :
                    (position <= len_m1) ? (len_m1 - position) : '0;
  assign pos_last = (position >= len_m1);

  // tap qualification; an entry never loaded reads as unused
  assign lag_m    = tap_rd_vld ? tap_rd[LAG_W+COEF_W-1:COEF_W] : '0;
  assign coef_m   = tap_rd_vld ? $signed(tap_rd[COEF_W-1:0]) : '0;
  assign tap_use  = (lag_m != '0) && (POS_W'(lag_m) <= iy) &&
                    (int'(lag_m) < WINDOW_DEPTH);
  assign lag_addr = WIN_AW'(iy - POS_W'(lag_m));
  assign last_tap = (tap_t == TAP_SW'(TAPS_PER_FILTER - 1));

  // window word as read, empty entries read as zero
  assign w_old = win_rd_vld ? $signed(win_rd_data) : '0;
  assign mul_b = adjoint_mode ? tt : w_old;

  // rounding to nearest, halves up
  assign acc_rnd   = (acc + ACC_W'(RND_HALF)) >>> FRAC_W;
  assign prod_half = PRODX_W'(prod) + PRODX_W'(RND_HALF);
  assign prod_rnd  = prod_half >>> FRAC_W;

  assign head_sat = sat_s32(SAT_IN_W'(sample_r) + SAT_IN_W'(w_old));
  assign fwd_sat  = sat_s32(SAT_IN_W'(acc_rnd));
  assign adj_sat  = sat_s32(SAT_IN_W'(w_old) - SAT_IN_W'(prod_rnd));
  assign fin_sat  = sat_s24(SAT_IN_W'(tt) +
                            (add_mode ? SAT_IN_W'(prior_r) : SAT_IN_W'(0)));
  assign fin_go   = !out_valid || result.ready;

  // window port control
  always_comb begin
    win_re    = 1'b0;
    win_raddr = WIN_AW'(iy);
    win_we    = 1'b0;
    win_waddr = WIN_AW'(iy);
    win_wdata = fwd_sat.value;
    case (state)
      S_START: win_re = 1'b1;
      S_LAG: begin
        win_re    = tap_use;
        win_raddr = lag_addr;
      end
      S_ACC: begin
        win_we    = adjoint_mode;
        win_waddr = tap_waddr;
        win_wdata = adj_sat.value;
      end
      S_RND: win_we = !adjoint_mode;
      default: ;
    endcase
  end

  // tap memory
  always_ff @(posedge clk) begin
    if (item_acc && !is_sample && load_ok) begin
      tap_mem[load_addr] <= {item.tap_lag, item.tap_coef};
    end
    if (state == S_TAP) begin
      tap_rd <= tap_mem[tap_addr];
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    if (win_re) begin
      win_rd_data <= win_mem[win_raddr];
    end
  end

  // sequencer, configuration, valid bits and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      position     <= '0;
      adjoint_mode <= 1'b0;
      add_mode     <= 1'b0;
      data_length  <= POS_W'(1);
      tap_t        <= '0;
      out_valid    <= 1'b0;
      tap_vld      <= '0;
      win_vld      <= '0;
      tap_rd_vld   <= 1'b0;
      win_rd_vld   <= 1'b0;
    end else begin
      // result word taken; a new one is raised from S_FIN instead
      if (out_valid && result.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (item_acc && !is_sample && load_ok) begin
        tap_vld[load_addr] <= 1'b1;
      end
      if (state == S_TAP) begin
        tap_rd_vld <= tap_vld[tap_addr];
      end
      if (win_re) begin
        win_rd_vld <= win_vld[win_raddr];
      end
      if (win_we) begin
        win_vld[win_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (item_acc && is_sample) begin
            state    <= S_START;
            position <= pos_last ? '0 : position + POS_W'(1);
            // a new data set starts from an empty window
            if (position == '0) begin
              win_vld <= '0;
            end
          end
        end
        S_START: state <= S_HEAD;
        S_HEAD: begin
          tap_t <= '0;
          // adjoint: the pending sum is consumed here
          if (adjoint_mode) begin
            win_vld[WIN_AW'(iy)] <= 1'b0;
          end
          state <= has_taps ? S_TAP : S_RND;
        end
        S_TAP: state <= S_LAG;
        S_LAG: begin
          if (tap_use) begin
            state <= S_WIN;
          end else if (last_tap) begin
            state <= S_RND;
          end else begin
            tap_t <= tap_t + TAP_SW'(1);
            state <= S_TAP;
          end
        end
        S_WIN: state <= S_ACC;
        S_ACC: begin
          if (last_tap) begin
            state <= S_RND;
          end else begin
            tap_t <= tap_t + TAP_SW'(1);
            state <= S_TAP;
          end
        end
        S_RND: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            out_value <= fin_sat.value;
            out_sat   <= flag32 || fin_sat.clip;
            out_last  <= last_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes; any known register restarts the data set
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_ADJOINT_MODE: begin
            adjoint_mode <= cfg.data[0];
            position     <= '0;
          end
          REG_ADD_MODE: begin
            add_mode <= cfg.data[0];
            position <= '0;
          end
          REG_DATA_LENGTH: begin
            data_length <= cfg.data;
            position    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // capture the sample word
    if (item_acc && is_sample) begin
      patch_r  <= item.patch_select;
      has_taps <= (int'(item.patch_select) < NUM_PATCHES);
      iy       <= pos_iy;
      last_r   <= pos_last;
      sample_r <= item.sample_value;
      prior_r  <= item.prior_value;
    end
    case (state)
      S_HEAD: begin
        if (adjoint_mode) begin
          tt     <= head_sat.value;
          flag32 <= head_sat.clip;
        end else begin
          acc    <= ACC_W'(sample_r) <<< FRAC_W;
          flag32 <= 1'b0;
        end
      end
      S_LAG: tap_waddr <= lag_addr;
      // shared multiplier
      S_WIN: prod <= PROD_W'(coef_m) * PROD_W'(mul_b);
      S_ACC: begin
        if (!adjoint_mode) begin
          acc <= acc - ACC_W'(prod);
        end
      end
      S_RND: begin
        if (!adjoint_mode) begin
          tt     <= fwd_sat.value;
          flag32 <= fwd_sat.clip;
        end
      end
      default: ;
    endcase
  end

  // checks
  `NHIF_ASSERT_NEXT(a_sample_starts, clk, rst, item.valid && item.ready && item.command == CMD_SAMPLE, state == S_START, "sample word did not start the sequencer")
  `NHIF_ASSERT_NEXT(a_fin_holds, clk, rst, state == S_FIN && result.valid && !result.ready, state == S_FIN, "result overwritten while stalled")
  `NHIF_ASSERT_NEXT(a_tap_loop_entry, clk, rst, state == S_HEAD && has_taps, state == S_TAP && tap_t == '0, "tap loop entered at wrong slot")
  `NHIF_ASSERT_IMPL(a_acc_after_mul, clk, rst, state == S_ACC, $past(state) == S_WIN, "accumulate without a product")
  `NHIF_ASSERT_IMPL(a_pos_bound, clk, rst, 1'b1, position <= len_m1, "position beyond data set")

endmodule
